### src/pal_pkg.sv
`timescale 1ns / 1ps
package pal_pkg;

  localparam int CapacityDef = 16;
  localparam int CapacityMax = 256;
  localparam int CntMaxW     = $clog2(CapacityMax + 1);
  localparam int OpW         = 3;
  localparam int PosW        = 5;
  localparam int LenW        = 5;
  localparam int ValW        = 32;
  localparam int StatW       = 3;
  localparam int OutCntW     = 5;
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);

  typedef enum logic [OpW-1:0] {
    OP_CREATE  = 3'd0,
    OP_LOAD    = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_SEARCH  = 3'd4,
    OP_DISPLAY = 3'd5
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_LIMIT    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    JOB_REPLY,
    JOB_LOAD,
    JOB_INSERT,
    JOB_DELETE,
    JOB_SEARCH,
    JOB_DISPLAY
  } job_e;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } bk_state_e;

  typedef struct packed {
    job_e                    kind;
    status_e                 status;
    logic [PosW-1:0]         pos0;
    logic signed [ValW-1:0]  value;
    logic [CntMaxW-1:0]      cnt;
    logic [OutCntW-1:0]      cnt_out;
  } job_t;

endpackage

### src/pal_front.sv
`timescale 1ns / 1ps
module pal_front import pal_pkg::*; #(
  parameter int CAPACITY = CapacityDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [OpW-1:0]         operation_i,
  input  logic [PosW-1:0]        position_i,
  input  logic [LenW-1:0]        length_i,
  input  logic signed [ValW-1:0] value_i,
  input  logic                   q_full_i,
  output logic                   busy_o,
  output logic                   push_o,
  output job_t                   job_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > PosW) ? CntW + 1 : PosW + 1;

  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] cnt_x, pos_x, len_x, cap_x;
  logic            pos_bad;

  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

  always_comb begin
    cnt_x   = CmpW'(count_q);
    pos_x   = CmpW'(position_i);
    len_x   = CmpW'(length_i);
    cap_x   = CmpW'(CAPACITY);
    pos_bad = (pos_x == '0) || (pos_x > cnt_x);
    count_d = count_q;

    job_o.kind    = JOB_REPLY;
    job_o.status  = ST_OK;
    job_o.pos0    = position_i - PosW'(1);
    job_o.value   = value_i;
    job_o.cnt     = CntMaxW'(count_q);

    unique case (operation_i)
      OP_CREATE: begin
        if (len_x > cap_x) begin
          job_o.status = ST_LIMIT;
          count_d      = '0;
        end else begin
          count_d = CntW'(length_i);
        end
      end
      OP_LOAD: begin
        if (pos_bad) begin
          job_o.status = ST_BADPOS;
        end else begin
          job_o.kind = JOB_LOAD;
        end
      end
      OP_INSERT: begin
        priority if (cnt_x >= cap_x) begin
          job_o.status = ST_FULL;
        end else if ((pos_x == '0) || (pos_x > cnt_x + CmpW'(1))) begin
          job_o.status = ST_BADPOS;
        end else begin
          job_o.kind = JOB_INSERT;
          count_d    = count_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        priority if (count_q == '0) begin
          job_o.status = ST_EMPTY;
        end else if (pos_bad) begin
          job_o.status = ST_BADPOS;
        end else begin
          job_o.kind = JOB_DELETE;
          count_d    = count_q - CntW'(1);
        end
      end
      OP_SEARCH: begin
        if (count_q == '0) begin
          job_o.status = ST_EMPTY;
        end else begin
          job_o.kind = JOB_SEARCH;
        end
      end
      OP_DISPLAY: begin
        if (count_q == '0) begin
          job_o.status = ST_EMPTY;
        end else begin
          job_o.kind = JOB_DISPLAY;
        end
      end
      default: begin
        job_o.status = ST_OK;
      end
    endcase

    job_o.cnt_out = OutCntW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_o) begin
      count_q <= count_d;
    end
  end

endmodule

### src/pal_queue.sv
`timescale 1ns / 1ps
module pal_queue import pal_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t               slot_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     fill_q;

  assign full_o  = (fill_q == (QPtrW + 1)'(QDepth));
  assign empty_o = (fill_q == '0);
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (QPtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (QPtrW + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

### src/pal_back.sv
`timescale 1ns / 1ps
module pal_back import pal_pkg::*; #(
  parameter int CAPACITY = CapacityDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  job_t                    q_job_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic [StatW-1:0]        status_o,
  output logic [PosW-1:0]         found_position_o,
  output logic signed [ValW-1:0]  element_o,
  output logic [OutCntW-1:0]      element_count_o,
  output logic                    last_result_o
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);

  bk_state_e state_q, state_d;
  job_t      job_q, job_d;
  logic [AddrW-1:0] idx_q, idx_d, idxp_q, idxp_d;
  logic [CntW-1:0]  rem_q, rem_d, n_in;
  logic             pv_q, pv_d;

  logic signed [ValW-1:0] mem_q [CAPACITY];
  logic signed [ValW-1:0] rd_q;
  logic                   rd_en, wr_en;
  logic [AddrW-1:0]       rd_addr, wr_addr, p0_in;
  logic signed [ValW-1:0] wr_data;

  logic                   emit, e_last;
  status_e                e_status;
  logic [PosW-1:0]        e_fpos;
  logic signed [ValW-1:0] e_elem;
  logic [OutCntW-1:0]     e_cnt;

  logic                   out_valid_q;
  logic [StatW-1:0]       out_status_q;
  logic [PosW-1:0]        out_fpos_q;
  logic signed [ValW-1:0] out_elem_q;
  logic [OutCntW-1:0]     out_cnt_q;
  logic                   out_last_q;

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    idx_d    = idx_q;
    idxp_d   = idxp_q;
    rem_d    = rem_q;
    pv_d     = 1'b0;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = AddrW'(job_q.pos0);
    wr_data  = job_q.value;
    emit     = 1'b0;
    e_status = ST_OK;
    e_fpos   = '0;
    e_elem   = '0;
    e_cnt    = job_q.cnt_out;
    e_last   = 1'b1;
    n_in     = CntW'(q_job_i.cnt);
    p0_in    = AddrW'(q_job_i.pos0);

    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          job_d = q_job_i;
          e_cnt = q_job_i.cnt_out;
          unique case (q_job_i.kind)
            JOB_REPLY: begin
              emit     = 1'b1;
              e_status = q_job_i.status;
            end
            JOB_LOAD: begin
              wr_en   = 1'b1;
              wr_addr = p0_in;
              wr_data = q_job_i.value;
              emit    = 1'b1;
            end
            JOB_INSERT: begin
              idx_d   = AddrW'(n_in - CntW'(1));
              rem_d   = n_in - CntW'(q_job_i.pos0);
              state_d = BK_WALK;
            end
            JOB_DELETE: begin
              idx_d   = p0_in + AddrW'(1);
              rem_d   = n_in - CntW'(q_job_i.pos0) - CntW'(1);
              state_d = BK_WALK;
            end
            JOB_SEARCH, JOB_DISPLAY: begin
              idx_d   = '0;
              rem_d   = n_in;
              state_d = BK_WALK;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      BK_WALK: begin
        if (rem_q != '0) begin
          rd_en  = 1'b1;
          pv_d   = 1'b1;
          idxp_d = idx_q;
          rem_d  = rem_q - CntW'(1);
          idx_d  = (job_q.kind == JOB_INSERT) ? idx_q - AddrW'(1) : idx_q + AddrW'(1);
        end
        if (pv_q) begin
          unique case (job_q.kind)
            JOB_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = idxp_q + AddrW'(1);
              wr_data = rd_q;
            end
            JOB_DELETE: begin
              wr_en   = 1'b1;
              wr_addr = idxp_q - AddrW'(1);
              wr_data = rd_q;
            end
            JOB_SEARCH: begin
              if (rd_q == job_q.value) begin
                emit    = 1'b1;
                e_fpos  = PosW'({1'b0, idxp_q} + (AddrW + 1)'(1));
                pv_d    = 1'b0;
                state_d = BK_IDLE;
              end
            end
            JOB_DISPLAY: begin
              emit   = 1'b1;
              e_elem = rd_q;
              e_last = (rem_q == '0);
              if (rem_q == '0) begin
                state_d = BK_IDLE;
              end
            end
            default: begin
              state_d = BK_IDLE;
            end
          endcase
        end else if (rem_q == '0) begin
          state_d = BK_IDLE;
          unique case (job_q.kind)
            JOB_INSERT: begin
              wr_en = 1'b1;
              emit  = 1'b1;
            end
            JOB_SEARCH: begin
              emit     = 1'b1;
              e_status = ST_NOTFOUND;
            end
            JOB_DELETE: begin
              emit = 1'b1;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pv_q        <= pv_d;
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    idx_q  <= idx_d;
    idxp_q <= idxp_d;
    rem_q  <= rem_d;
    if (emit) begin
      out_status_q <= e_status;
      out_fpos_q   <= e_fpos;
      out_elem_q   <= e_elem;
      out_cnt_q    <= e_cnt;
      out_last_q   <= e_last;
    end
  end

  assign done_o           = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_fpos_q;
  assign element_o        = out_elem_q;
  assign element_count_o  = out_cnt_q;
  assign last_result_o    = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE) |-> !pv_q)
    else $error("pending read outside walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write collide on one entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_OK)) |-> out_last_q)
    else $error("error result not marked last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BK_IDLE))
    else $error("job taken while walking");

endmodule

### src/positional_array_list_unit.sv
`timescale 1ns / 1ps
// Positional array list: an ordered list of signed 32-bit entries with a count.
// Input: drive operation_i, position_i, length_i, value_i and raise start; the
// item is taken at a rising edge where start is high and busy is low.
// Output: each result shows for one cycle with done_o high; last_result_o marks
// the final result of an item. The receiver cannot stall the block.
// The front end checks the item against the entry count and queues a job (two
// deep); busy rises only while that queue is full. The back end runs one job
// at a time over a single-port-write, single-read entry memory.
// Create, load and every rejected item are answered straight from the queue,
// with no walk over the entries. Insert and delete move one entry per cycle;
// search and display read one entry per cycle, and display emits one result
// per cycle.
// Reset empties the list; entry contents stay undefined until loaded or
// inserted. No clearing pass runs.
module positional_array_list_unit import pal_pkg::*; #(
  parameter int CAPACITY = CapacityDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [OpW-1:0]         operation_i,
  input  logic [PosW-1:0]        position_i,
  input  logic [LenW-1:0]        length_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   done_o,
  output logic [StatW-1:0]       status_o,
  output logic [PosW-1:0]        found_position_o,
  output logic signed [ValW-1:0] element_o,
  output logic [OutCntW-1:0]     element_count_o,
  output logic                   last_result_o
);

  logic push, pop, q_full, q_empty;
  job_t push_job, pop_job;

  pal_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .position_i  (position_i),
    .length_i    (length_i),
    .value_i     (value_i),
    .q_full_i    (q_full),
    .busy_o      (busy),
    .push_o      (push),
    .job_o       (push_job)
  );

  pal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pal_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_job_i          (pop_job),
    .pop_o            (pop),
    .done_o           (done_o),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .element_o        (element_o),
    .element_count_o  (element_count_o),
    .last_result_o    (last_result_o)
  );

endmodule

### tb/positional_array_list_unit_tb.sv
`timescale 1ns / 1ps
module positional_array_list_unit_tb;
  import pal_pkg::*;

  localparam int Capacity = CapacityDef;
  localparam logic [OpW-1:0] OpSpareA = 3'd6;
  localparam logic [OpW-1:0] OpSpareB = 3'd7;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam int MaxReports = 10;

  typedef struct {
    status_e                status;
    logic [PosW-1:0]        fpos;
    logic signed [ValW-1:0] elem;
    logic [OutCntW-1:0]     cnt;
    logic                   last;
  } list_result_t;

  class list_tracker;
    logic signed [ValW-1:0] slots[Capacity];
    bit                     written[Capacity];
    int unsigned            count;
    list_result_t           pending[$];
    int unsigned            mismatches;

    function void push(status_e st, int unsigned fpos, logic signed [ValW-1:0] el, bit last);
      list_result_t r;
      r.status = st;
      r.fpos   = fpos[PosW-1:0];
      r.elem   = el;
      r.cnt    = count[OutCntW-1:0];
      r.last   = last;
      pending.push_back(r);
    endfunction

    // Entries that the operation will read must hold defined data.
    function bit reads_ok(logic [OpW-1:0] op, int unsigned pos);
      int lo;
      int hi;
      bit ok;
      lo = 0;
      hi = -1;
      case (op)
        OP_SEARCH, OP_DISPLAY: hi = int'(count) - 1;
        OP_INSERT: if (count < Capacity && pos >= 1 && pos <= count + 1) begin
          lo = int'(pos) - 1;
          hi = int'(count) - 1;
        end
        OP_DELETE: if (pos >= 1 && pos <= count) begin
          lo = int'(pos);
          hi = int'(count) - 1;
        end
        default: ;
      endcase
      ok = 1'b1;
      for (int k = lo; k <= hi; k++) if (!written[k]) ok = 1'b0;
      return ok;
    endfunction

    function int first_unwritten();
      for (int k = 0; k < int'(count); k++) if (!written[k]) return k;
      return -1;
    endfunction

    function void accept_item(logic [OpW-1:0] op, int unsigned pos, int unsigned len,
                              logic signed [ValW-1:0] val);
      int unsigned found;
      case (op)
        OP_CREATE: begin
          if (len > Capacity) begin
            count = 0;
            push(ST_LIMIT, 0, 0, 1'b1);
          end else begin
            count = len;
            push(ST_OK, 0, 0, 1'b1);
          end
        end
        OP_LOAD: begin
          if (pos < 1 || pos > count) push(ST_BADPOS, 0, 0, 1'b1);
          else begin
            slots[pos-1]   = val;
            written[pos-1] = 1'b1;
            push(ST_OK, 0, 0, 1'b1);
          end
        end
        OP_INSERT: begin
          if (count >= Capacity) push(ST_FULL, 0, 0, 1'b1);
          else if (pos < 1 || pos > count + 1) push(ST_BADPOS, 0, 0, 1'b1);
          else begin
            for (int k = int'(count); k >= int'(pos); k--) begin
              slots[k]   = slots[k-1];
              written[k] = written[k-1];
            end
            slots[pos-1]   = val;
            written[pos-1] = 1'b1;
            count++;
            push(ST_OK, 0, 0, 1'b1);
          end
        end
        OP_DELETE: begin
          if (count == 0) push(ST_EMPTY, 0, 0, 1'b1);
          else if (pos < 1 || pos > count) push(ST_BADPOS, 0, 0, 1'b1);
          else begin
            for (int k = int'(pos) - 1; k + 1 < int'(count); k++) begin
              slots[k]   = slots[k+1];
              written[k] = written[k+1];
            end
            count--;
            push(ST_OK, 0, 0, 1'b1);
          end
        end
        OP_SEARCH: begin
          found = 0;
          for (int k = 0; k < int'(count); k++)
            if (found == 0 && slots[k] == val) found = k + 1;
          if (count == 0) push(ST_EMPTY, 0, 0, 1'b1);
          else if (found != 0) push(ST_OK, found, 0, 1'b1);
          else push(ST_NOTFOUND, 0, 0, 1'b1);
        end
        OP_DISPLAY: begin
          if (count == 0) push(ST_EMPTY, 0, 0, 1'b1);
          else
            for (int k = 0; k < int'(count); k++)
              push(ST_OK, 0, slots[k], k + 1 == int'(count));
        end
        default: push(ST_OK, 0, 0, 1'b1);
      endcase
    endfunction

    function void check_result(logic [StatW-1:0] st, logic [PosW-1:0] fp,
                               logic signed [ValW-1:0] el, logic [OutCntW-1:0] cnt,
                               logic last);
      list_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result status=%0d fpos=%0d elem=%0d count=%0d last=%0b",
                   $realtime, st, fp, el, cnt, last);
        return;
      end
      exp = pending.pop_front();
      if (st !== exp.status || fp !== exp.fpos || el !== exp.elem || cnt !== exp.cnt ||
          last !== exp.last) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected status=%0d fpos=%0d elem=%0d count=%0d last=%0b",
                   exp.status, exp.fpos, exp.elem, exp.cnt, exp.last);
          $display("  actual   status=%0d fpos=%0d elem=%0d count=%0d last=%0b",
                   st, fp, el, cnt, last);
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [OpW-1:0]         operation_i;
  logic [PosW-1:0]        position_i;
  logic [LenW-1:0]        length_i;
  logic signed [ValW-1:0] value_i;
  logic                   done_o;
  logic [StatW-1:0]       status_o;
  logic [PosW-1:0]        found_position_o;
  logic signed [ValW-1:0] element_o;
  logic [OutCntW-1:0]     element_count_o;
  logic                   last_result_o;

  list_tracker sb = new();
  int          idle_pct;
  int          idle_pcts[4] = '{0, 69, 0, 32};

  positional_array_list_unit #(.CAPACITY(Capacity)) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .position_i       (position_i),
    .length_i         (length_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .element_o        (element_o),
    .element_count_o  (element_count_o),
    .last_result_o    (last_result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(status_o, found_position_o, element_o, element_count_o, last_result_o);
  end

  task automatic send_item(logic [OpW-1:0] op, logic [PosW-1:0] pos, logic [LenW-1:0] len,
                           logic signed [ValW-1:0] val);
    start       <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    length_i    <= len;
    value_i     <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.accept_item(op, pos, len, val);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic random_item();
    int unsigned            pick;
    int unsigned            cnt;
    int                     hole;
    logic [OpW-1:0]         op;
    logic [PosW-1:0]        pos;
    logic [LenW-1:0]        len;
    logic signed [ValW-1:0] val;
    pick = $urandom_range(0, 99);
    cnt  = sb.count;
    pos  = PosW'($urandom);
    len  = LenW'($urandom);
    val  = $urandom;
    case ($urandom_range(0, 19))
      0: val = ValMin;
      1: val = ValMax;
      2: val = '0;
      3: val = -1;
      default: ;
    endcase
    if (pick < 6) begin
      op = OP_CREATE;
      case ($urandom_range(0, 9))
        0, 1: len = LenW'($urandom_range(Capacity + 1, 31));
        2, 3: len = LenW'(Capacity);
        default: len = LenW'($urandom_range(0, Capacity));
      endcase
    end else if (pick < 26) begin
      op = OP_LOAD;
      hole = sb.first_unwritten();
      if (hole >= 0 && $urandom_range(0, 99) < 60) pos = PosW'(hole + 1);
      else if (cnt > 0 && $urandom_range(0, 9) != 0) pos = PosW'($urandom_range(1, cnt));
    end else if (pick < 48) begin
      op = OP_INSERT;
      if ($urandom_range(0, 9) != 0) pos = PosW'($urandom_range(1, cnt + 1));
    end else if (pick < 63) begin
      op = OP_DELETE;
      if (cnt > 0 && $urandom_range(0, 9) != 0) pos = PosW'($urandom_range(1, cnt));
    end else if (pick < 80) begin
      op = OP_SEARCH;
      if (cnt > 0 && $urandom_range(0, 99) < 60) val = sb.slots[$urandom_range(0, cnt - 1)];
    end else if (pick < 90) begin
      op = OP_DISPLAY;
    end else if (pick < 97) begin
      case ($urandom_range(0, 2))
        0: op = OP_LOAD;
        1: op = OP_INSERT;
        default: op = OP_DELETE;
      endcase
    end else begin
      op = $urandom_range(0, 1) ? OpSpareA : OpSpareB;
    end
    if (!sb.reads_ok(op, pos)) begin
      hole = sb.first_unwritten();
      op   = OP_LOAD;
      pos  = PosW'(hole + 1);
    end
    send_item(op, pos, len, val);
  endtask

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    operation_i <= '0;
    position_i  <= '0;
    length_i    <= '0;
    value_i     <= '0;
    idle_pct     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_DISPLAY, 0, 0, 0);
    send_item(OP_SEARCH, 0, 0, 5);
    send_item(OP_DELETE, 1, 0, 0);
    send_item(OP_LOAD, 1, 0, 7);
    send_item(OP_CREATE, 0, 17, 0);
    send_item(OP_CREATE, 0, 31, 0);
    send_item(OP_INSERT, 0, 0, 1);
    send_item(OP_INSERT, 2, 0, 1);
    send_item(OP_INSERT, 1, 0, ValMin);
    send_item(OP_INSERT, 2, 0, ValMax);
    send_item(OP_INSERT, 1, 0, -1);
    send_item(OP_SEARCH, 0, 0, ValMax);
    send_item(OP_SEARCH, 0, 0, 0);
    send_item(OP_DISPLAY, 0, 0, 0);
    send_item(OP_DELETE, 4, 0, 0);
    send_item(OP_DELETE, 31, 0, 0);
    send_item(OP_DELETE, 2, 0, 0);
    send_item(OP_LOAD, 3, 0, 9);
    send_item(OP_CREATE, 0, 3, 0);
    send_item(OP_LOAD, 3, 0, 32'sh5555_AAAA);
    send_item(OpSpareA, 31, 31, -1);
    send_item(OpSpareB, 0, 0, 0);
    send_item(OP_DISPLAY, 0, 0, 0);
    send_item(OP_CREATE, 0, 0, 0);
    send_item(OP_DISPLAY, 0, 0, 0);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = idle_pcts[phase];
      repeat (36) random_item();
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Capacity + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
